// ===== sv/rlws_pkg.sv =====
`timescale 1ns / 1ps
// rlws_pkg: shared widths, reset constant, result record and sequencer states
// for the run-length window sum/max block; no dependencies
package rlws_pkg;

    localparam int RUN_W  = 31;   // run length and repeat count
    localparam int VAL_W  = 16;   // run value and window max
    localparam int WL_W   = 17;   // window length, fill and span
    localparam int OSUM_W = 32;   // window sum as delivered

    localparam logic [WL_W-1:0] WL_RESET = 17'd1000;

    typedef struct packed {
        logic [OSUM_W-1:0] sum;
        logic [VAL_W-1:0]  vmax;
        logic [RUN_W-1:0]  repeat_cnt;
        logic [WL_W-1:0]   span;
        logic              last;
    } t_result;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_FILL  = 12'b0000_0000_0010,
        S_FMUL  = 12'b0000_0000_0100,
        S_FADD  = 12'b0000_0000_1000,
        S_CLOSE = 12'b0000_0001_0000,
        S_DCHK  = 12'b0000_0010_0000,
        S_DIV   = 12'b0000_0100_0000,
        S_WMUL  = 12'b0000_1000_0000,
        S_WEMIT = 12'b0001_0000_0000,
        S_REM   = 12'b0010_0000_0000,
        S_RADD  = 12'b0100_0000_0000,
        S_FLUSH = 12'b1000_0000_0000
    } t_state;

endpackage

// ===== sv/rle_window_sum_max_top.sv =====
`timescale 1ns / 1ps
// Run-length window sum and max: takes coverage runs (length, value, final flag) and cuts
// positions into back-to-back windows of the configured length, giving per window the
// saturating sum of value times positions, the largest value, a repeat count for runs
// that cover several whole windows, and the span. A run that tops up an open window
// first passes the fill multiply, add and close states; a run that covers whole windows
// also waits for the 31-step serial divider. Each time the output holds back an emitted
// result, the sequencer stalls until it is taken. One run is worked at a time; a finished
// result waits in a one-entry output register so the next run can be taken meanwhile.
// Up to three results come per run; tlast marks the last one of each run.
// Depends on rlws_pkg, rlws_div and rlws_obuf.
module rle_window_sum_max_top #(
    parameter int VALUE_BITS = 16,
    parameter int SUM_BITS   = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [16:0] i_cfg_data,     // window_length
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // run_length[30:0], run_value[46:31], zero pad
    input  logic        s_axis_tlast,   // final_run
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // window_sum[31:0], window_max[47:32],
                                        // window_repeat[78:48], window_span[95:79]
    output logic        m_axis_tlast    // last
);

    localparam int RW     = rlws_pkg::RUN_W;
    localparam int VW     = rlws_pkg::VAL_W;
    localparam int WW     = rlws_pkg::WL_W;
    localparam int OW     = rlws_pkg::OSUM_W;
    localparam int PROD_W = VW + RW;
    localparam int ACC_W  = ((SUM_BITS > PROD_W) ? SUM_BITS : PROD_W) + 1;
    localparam int SUMX_W = (SUM_BITS > OW) ? SUM_BITS : OW;

    localparam logic [VW-1:0] VMASK = (VALUE_BITS >= VW) ? {VW{1'b1}} :
                                      VW'((64'd1 << VALUE_BITS) - 64'd1);
    localparam logic [ACC_W-1:0] SUM_MAX_A = {{(ACC_W-SUM_BITS){1'b0}}, {SUM_BITS{1'b1}}};

    function automatic logic [SUM_BITS-1:0] f_sat(input logic [SUM_BITS-1:0] a,
                                                  input logic [PROD_W-1:0] b);
        logic [ACC_W-1:0] s;
        s = ACC_W'(a) + ACC_W'(b);
        if (s > SUM_MAX_A) begin
            s = SUM_MAX_A;
        end
        return s[SUM_BITS-1:0];
    endfunction

    function automatic logic [OW-1:0] f_osum(input logic [SUM_BITS-1:0] a);
        logic [SUMX_W-1:0] x;
        x = SUMX_W'(a);
        return x[OW-1:0];
    endfunction

    rlws_pkg::t_state  r_state;
    rlws_pkg::t_state  n_state;

    logic [WW-1:0]       r_wl;
    logic [WW-1:0]       r_wle;
    logic [RW-1:0]       r_rem;
    logic [VW-1:0]       r_v;
    logic                r_fin;
    logic [WW-1:0]       r_t;
    logic [RW-1:0]       r_n;
    logic [PROD_W-1:0]   r_prod;
    logic [WW-1:0]       r_fill;
    logic [SUM_BITS-1:0] r_psum;
    logic [VW-1:0]       r_pmax;

    logic                w_accept;
    logic [WW-1:0]       w_room;
    logic [WW-1:0]       w_t;
    logic [RW-1:0]       w_mop;
    logic                w_more_close;

    logic                w_emit;
    logic                w_obuf_ready;
    rlws_pkg::t_result   w_res;
    rlws_pkg::t_result   w_ores;

    logic                w_div_start;
    logic                w_div_busy;
    logic                w_div_done;
    logic [RW-1:0]       w_quot;
    logic [WW-1:0]       w_drem;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == rlws_pkg::S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wl <= rlws_pkg::WL_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_wl <= i_cfg_data;
        end
    end

    // room left in the open window and the part of the run that goes into it
    always_comb begin
        w_room = (r_fill < r_wle) ? (r_wle - r_fill) : '0;
        w_t    = (r_rem < RW'(w_room)) ? r_rem[WW-1:0] : w_room;
        w_more_close = (r_rem != '0) && ((r_rem >= RW'(r_wle)) || r_fin);
    end

    // operand for the shared multiplier
    always_comb begin
        case (r_state)
            rlws_pkg::S_FMUL: w_mop = RW'(r_t);
            rlws_pkg::S_WMUL: w_mop = RW'(r_wle);
            default:          w_mop = r_rem;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        w_emit      = 1'b0;
        w_div_start = 1'b0;
        w_res       = '0;
        unique case (r_state)
            rlws_pkg::S_IDLE: begin
                if (w_accept) n_state = rlws_pkg::S_FILL;
            end
            rlws_pkg::S_FILL: begin
                n_state = (r_fill == '0) ? rlws_pkg::S_DCHK : rlws_pkg::S_FMUL;
            end
            rlws_pkg::S_FMUL: n_state = rlws_pkg::S_FADD;
            rlws_pkg::S_FADD: n_state = rlws_pkg::S_CLOSE;
            rlws_pkg::S_CLOSE: begin
                if (r_fill >= r_wle) begin
                    w_emit           = 1'b1;
                    w_res.sum        = f_osum(r_psum);
                    w_res.vmax       = r_pmax;
                    w_res.repeat_cnt = RW'(1);
                    w_res.span       = r_fill;
                    w_res.last       = !w_more_close;
                    if (w_obuf_ready) n_state = rlws_pkg::S_DCHK;
                end else begin
                    n_state = rlws_pkg::S_DCHK;
                end
            end
            rlws_pkg::S_DCHK: begin
                if (r_rem >= RW'(r_wle)) begin
                    w_div_start = 1'b1;
                    n_state     = rlws_pkg::S_DIV;
                end else begin
                    n_state = rlws_pkg::S_REM;
                end
            end
            rlws_pkg::S_DIV: begin
                if (w_div_done) n_state = rlws_pkg::S_WMUL;
            end
            rlws_pkg::S_WMUL: n_state = rlws_pkg::S_WEMIT;
            rlws_pkg::S_WEMIT: begin
                w_emit           = 1'b1;
                w_res.sum        = f_osum(f_sat('0, r_prod));
                w_res.vmax       = r_v;
                w_res.repeat_cnt = r_n;
                w_res.span       = r_wle;
                w_res.last       = !(r_fin && (r_rem != '0));
                if (w_obuf_ready) n_state = rlws_pkg::S_REM;
            end
            rlws_pkg::S_REM: begin
                n_state = (r_rem != '0) ? rlws_pkg::S_RADD : rlws_pkg::S_FLUSH;
            end
            rlws_pkg::S_RADD: n_state = rlws_pkg::S_FLUSH;
            rlws_pkg::S_FLUSH: begin
                if (r_fin && (r_fill != '0)) begin
                    w_emit           = 1'b1;
                    w_res.sum        = f_osum(r_psum);
                    w_res.vmax       = r_pmax;
                    w_res.repeat_cnt = RW'(1);
                    w_res.span       = r_fill;
                    w_res.last       = 1'b1;
                    if (w_obuf_ready) n_state = rlws_pkg::S_IDLE;
                end else begin
                    n_state = rlws_pkg::S_IDLE;
                end
            end
            default: n_state = rlws_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rlws_pkg::S_IDLE;
            r_fill  <= '0;
            r_psum  <= '0;
            r_pmax  <= '0;
        end else begin
            r_state <= n_state;
            case (r_state) inside
                rlws_pkg::S_FADD: begin
                    if (r_t != '0) begin
                        r_psum <= f_sat(r_psum, r_prod);
                        r_fill <= r_fill + r_t;
                        if (r_v > r_pmax) r_pmax <= r_v;
                    end
                end
                rlws_pkg::S_RADD: begin
                    r_fill <= r_rem[WW-1:0];
                    r_psum <= f_sat('0, r_prod);
                    r_pmax <= r_v;
                end
                rlws_pkg::S_CLOSE, rlws_pkg::S_FLUSH: begin
                    // window handed to the output register, start an empty one
                    if (w_emit && w_obuf_ready) begin
                        r_fill <= '0;
                        r_psum <= '0;
                        r_pmax <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rem <= s_axis_tdata[RW-1:0];
            r_v   <= s_axis_tdata[RW+VW-1:RW] & VMASK;
            r_fin <= s_axis_tlast;
            r_wle <= (r_wl == '0) ? WW'(1) : r_wl;
        end
        if (r_state == rlws_pkg::S_FILL) begin
            r_t <= w_t;
        end
        if (r_state == rlws_pkg::S_FMUL) begin
            r_rem <= r_rem - RW'(r_t);
        end
        if (r_state == rlws_pkg::S_DIV && w_div_done) begin
            r_n   <= w_quot;
            r_rem <= RW'(w_drem);
        end
        if (r_state == rlws_pkg::S_FMUL || r_state == rlws_pkg::S_WMUL ||
            r_state == rlws_pkg::S_REM) begin
            r_prod <= PROD_W'(r_v) * PROD_W'(w_mop);
        end
    end

    rlws_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_rem),
        .i_divisor  (r_wle),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_drem)
    );

    rlws_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_emit),
        .o_ready (w_obuf_ready),
        .i_res   (w_res),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (w_ores)
    );

    assign m_axis_tdata = {w_ores.span, w_ores.repeat_cnt, w_ores.vmax, w_ores.sum};
    assign m_axis_tlast = w_ores.last;

    // an empty open window carries no sum and no max
    a_empty_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rlws_pkg::S_IDLE && r_fill == '0) |-> (r_psum == '0 && r_pmax == '0))
        else $error("empty window holds a sum or max");

    // divider only runs when at least one whole window fits
    a_div_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rlws_pkg::S_DIV && w_div_done) |-> (w_quot != '0 && w_drem < r_wle))
        else $error("divider result out of range");

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rlws_pkg::S_IDLE) |-> !w_div_busy)
        else $error("divider busy while sequencer idle");

    a_max_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rlws_pkg::S_FADD && r_t != '0) |=> (r_pmax >= r_v))
        else $error("window max below run value");

endmodule

// ===== sv/rlws_div.sv =====
`timescale 1ns / 1ps
// rlws_div: restoring serial divider, one quotient bit per cycle
// depends on rlws_pkg for the run length and window length widths
module rlws_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [rlws_pkg::RUN_W-1:0] i_dividend,
    input  logic [rlws_pkg::WL_W-1:0]  i_divisor,
    output logic                     o_busy,
    output logic                     o_done,
    output logic [rlws_pkg::RUN_W-1:0] o_quot,
    output logic [rlws_pkg::WL_W-1:0]  o_rem
);

    localparam int RW    = rlws_pkg::RUN_W;
    localparam int DW    = rlws_pkg::WL_W;
    localparam int CNT_W = $clog2(RW);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [RW-1:0]    r_quot;
    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_div;

    logic [DW:0]      w_trial;
    logic [DW:0]      w_diff;
    logic             w_ge;
    logic [DW-1:0]    n_rem;

    // dividend bits shift out the top of r_quot while quotient bits shift in
    always_comb begin
        w_trial = {r_rem, r_quot[RW-1]};
        w_diff  = w_trial - {1'b0, r_div};
        w_ge    = (w_trial >= {1'b0, r_div});
        n_rem   = w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(RW - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[RW-2:0], w_ge};
            r_rem  <= n_rem;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

// ===== sv/rlws_obuf.sv =====
`timescale 1ns / 1ps
// rlws_obuf: one-entry result register between the sequencer and the output stream
// depends on rlws_pkg for the result record
module rlws_obuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  rlws_pkg::t_result i_res,
    output logic              o_valid,
    input  logic              i_ready,
    output rlws_pkg::t_result o_res
);

    logic              r_valid;
    rlws_pkg::t_result r_res;

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule
